[src/hcsc_pkg.sv]
// Shared types and constants for the hyperplane cell slice cull block.
// No dependencies.
`default_nettype none
package hcsc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CamW   = 32;
  localparam int unsigned NormW  = 16;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned SpW    = HalfW + 2;          // 2*half, with a zero sign bit
  localparam int unsigned ProdW  = CoordW + SpW;       // coord * sp
  localparam int unsigned OffW   = ProdW + 2;          // corner offset, Q.16
  localparam int unsigned DotW   = NormW + OffW;       // one axis term, Q.30
  localparam int unsigned SumW   = DotW + 2;           // sum of three terms

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 8 * CoordW;
  localparam int unsigned OutDataW = 8;

  localparam int unsigned CellsPerSideDef = 8;
  localparam int unsigned NumAxes = 3;

  localparam logic [NormW-1:0] NormalWReset   = 16'd16384;
  localparam logic [HalfW-1:0] BlockHalfReset = 24'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAM_X      = 3'd0,
    CFG_CAM_Z      = 3'd1,
    CFG_CAM_W      = 3'd2,
    CFG_NORMAL_X   = 3'd3,
    CFG_NORMAL_Z   = 3'd4,
    CFG_NORMAL_W   = 3'd5,
    CFG_BLOCK_HALF = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CamW-1:0]  cam_x;
    logic signed [CamW-1:0]  cam_z;
    logic signed [CamW-1:0]  cam_w;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_z;
    logic signed [NormW-1:0] normal_w;
    logic [HalfW-1:0]        block_half;
  } cfg_t;

  // Load enables of the three datapath stages ahead of the output register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage
`default_nettype wire

[src/hcsc_cfg_regs.sv]
// Configuration register file: camera position, plane normal, cell half size.
// Depends on hcsc_pkg.
`default_nettype none
module hcsc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hcsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hcsc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output hcsc_pkg::cfg_t                      cfg_o
);

  hcsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hcsc_pkg::cfg_idx_e'(cfg_idx_i))
        hcsc_pkg::CFG_CAM_X:      cfg_d.cam_x      = cfg_wdata_i;
        hcsc_pkg::CFG_CAM_Z:      cfg_d.cam_z      = cfg_wdata_i;
        hcsc_pkg::CFG_CAM_W:      cfg_d.cam_w      = cfg_wdata_i;
        hcsc_pkg::CFG_NORMAL_X:   cfg_d.normal_x   = cfg_wdata_i[hcsc_pkg::NormW-1:0];
        hcsc_pkg::CFG_NORMAL_Z:   cfg_d.normal_z   = cfg_wdata_i[hcsc_pkg::NormW-1:0];
        hcsc_pkg::CFG_NORMAL_W:   cfg_d.normal_w   = cfg_wdata_i[hcsc_pkg::NormW-1:0];
        hcsc_pkg::CFG_BLOCK_HALF: cfg_d.block_half = cfg_wdata_i[hcsc_pkg::HalfW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_x      <= '0;
      cfg_q.cam_z      <= '0;
      cfg_q.cam_w      <= '0;
      cfg_q.normal_x   <= '0;
      cfg_q.normal_z   <= '0;
      cfg_q.normal_w   <= hcsc_pkg::NormalWReset;
      cfg_q.block_half <= hcsc_pkg::BlockHalfReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[src/hcsc_axis_dot.sv]
// One axis of the min/max dot product: cell scale, corner select, normal multiply.
// Three register stages; depends on hcsc_pkg.
`default_nettype none
module hcsc_axis_dot (
  input  wire logic                                    clk_i,
  input  wire hcsc_pkg::stage_en_t                     en_i,
  input  wire logic signed [hcsc_pkg::CoordW-1:0]      coord_i,
  input  wire logic signed [hcsc_pkg::CamW-1:0]        cam_i,
  input  wire logic signed [hcsc_pkg::NormW-1:0]       normal_i,
  input  wire logic        [hcsc_pkg::HalfW-1:0]       half_i,
  output logic signed      [hcsc_pkg::DotW-1:0]        dot_min_o,
  output logic signed      [hcsc_pkg::DotW-1:0]        dot_max_o
);

  logic signed [hcsc_pkg::SpW-1:0]   sp;
  logic signed [hcsc_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [hcsc_pkg::OffW-1:0]  base, half_ext, lo, hi;
  logic signed [hcsc_pkg::OffW-1:0]  amin_d, amin_q, amax_d, amax_q;
  logic signed [hcsc_pkg::DotW-1:0]  pmin_d, pmin_q, pmax_d, pmax_q;

  assign sp     = $signed({1'b0, half_i, 1'b0});
  assign prod_d = coord_i * sp;

  assign half_ext = $signed({{(hcsc_pkg::OffW - hcsc_pkg::HalfW){1'b0}}, half_i});
  assign base     = hcsc_pkg::OffW'(prod_q) - hcsc_pkg::OffW'(cam_i);
  assign lo       = base - half_ext;
  assign hi       = base + half_ext;
  // negative normal swaps corners; a zero normal zeroes both terms anyway
  assign amin_d   = normal_i[hcsc_pkg::NormW-1] ? hi : lo;
  assign amax_d   = normal_i[hcsc_pkg::NormW-1] ? lo : hi;

  assign pmin_d = normal_i * amin_q;
  assign pmax_d = normal_i * amax_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_q <= prod_d;
    end
    if (en_i.s2) begin
      amin_q <= amin_d;
      amax_q <= amax_d;
    end
    if (en_i.s3) begin
      pmin_q <= pmin_d;
      pmax_q <= pmax_d;
    end
  end

  assign dot_min_o = pmin_q;
  assign dot_max_o = pmax_q;

endmodule
`default_nettype wire

[src/hcsc_interior.sv]
// Superblock interior test on all four axes, registered at the first stage.
// Depends on hcsc_pkg.
`default_nettype none
module hcsc_interior #(
  parameter int unsigned CELLS_PER_SIDE = hcsc_pkg::CellsPerSideDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [4*hcsc_pkg::CoordW-1:0]      cell_i,   // x, y, z, w from bit 0
  input  wire logic [4*hcsc_pkg::CoordW-1:0]      group_i,  // x, y, z, w from bit 0
  output logic                                    interior_o
);

  localparam int unsigned LocW = hcsc_pkg::CoordW + $clog2(CELLS_PER_SIDE) + 2;
  localparam logic signed [LocW-1:0] Side    = LocW'(CELLS_PER_SIDE);
  localparam logic signed [LocW-1:0] LastIdx = LocW'(CELLS_PER_SIDE - 1);

  logic [3:0] inner;
  logic       interior_q;

  for (genvar a = 0; a < 4; a++) begin : g_axis
    logic signed [hcsc_pkg::CoordW-1:0] c, g;
    logic signed [LocW-1:0]             local_off;
    assign c         = cell_i[a*hcsc_pkg::CoordW +: hcsc_pkg::CoordW];
    assign g         = group_i[a*hcsc_pkg::CoordW +: hcsc_pkg::CoordW];
    assign local_off = LocW'(c) - LocW'(g) * Side;
    assign inner[a]  = (local_off > 0) && (local_off < LastIdx);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      interior_q <= &inner;
    end
  end

  assign interior_o = interior_q;

endmodule
`default_nettype wire

[src/hyperplane_cell_slice_cull.sv]
// Top level: stream ports, pipeline control, dot-product sum and plane compare.
// Depends on hcsc_pkg, hcsc_cfg_regs, hcsc_axis_dot, hcsc_interior.
//
// Usage: one cell per input transaction on the s_axis group; one result per
// cell on the m_axis group, in order. Registers are written through the
// cfg_we_i / cfg_idx_i / cfg_wdata_i port while no cell is in flight; an
// index beyond the register list is ignored.
// An accepted input passes the registered steps corner scale multiply, corner
// select and normal multiply, then sum and compare into the output register,
// which drives m_axis_tvalid_o. Throughput is one cell per clock while the
// receiver does not stall; the two multiplier stages set the stage depth.
// When the receiver stalls, each full stage holds while the one after it holds,
// so s_axis_tready_o drops only once the pipeline has filled; no transaction
// is lost or repeated. Reset empties the pipeline and loads the register
// defaults: camera at origin, normal along +w, half cell size 0.5.
`default_nettype none
module hyperplane_cell_slice_cull #(
  parameter int unsigned CELLS_PER_SIDE = hcsc_pkg::CellsPerSideDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [hcsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [hcsc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // cell_x, cell_y, cell_z, cell_w, group_x, group_y, group_z, group_w
  input  wire logic [hcsc_pkg::InDataW-1:0]       s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // crosses_plane, visible, zero pad
  output logic [hcsc_pkg::OutDataW-1:0]           m_axis_tdata_o
);

  localparam int unsigned CW = hcsc_pkg::CoordW;

  hcsc_pkg::cfg_t      cfg;
  hcsc_pkg::stage_en_t en;
  logic                en4;
  logic                v1_q, v2_q, v3_q, v4_q;
  logic                int1, int2_q, int3_q;
  logic                crosses_d, crosses_q, visible_d, visible_q;

  logic signed [CW-1:0] coord [hcsc_pkg::NumAxes];
  logic signed [hcsc_pkg::CamW-1:0]  cam  [hcsc_pkg::NumAxes];
  logic signed [hcsc_pkg::NormW-1:0] nrm  [hcsc_pkg::NumAxes];
  logic signed [hcsc_pkg::DotW-1:0]  dmin [hcsc_pkg::NumAxes];
  logic signed [hcsc_pkg::DotW-1:0]  dmax [hcsc_pkg::NumAxes];
  logic signed [hcsc_pkg::SumW-1:0]  sum_min, sum_max;

  hcsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // a stage loads when it is empty or the next stage moves
  assign en4    = !v4_q || m_axis_tready_i;
  assign en.s3  = !v3_q || en4;
  assign en.s2  = !v2_q || en.s3;
  assign en.s1  = !v1_q || en.s2;
  assign s_axis_tready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= s_axis_tvalid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en4)   v4_q <= v3_q;
    end
  end

  assign coord[0] = s_axis_tdata_i[0*CW +: CW];
  assign coord[1] = s_axis_tdata_i[2*CW +: CW];
  assign coord[2] = s_axis_tdata_i[3*CW +: CW];
  assign cam[0]   = cfg.cam_x;
  assign cam[1]   = cfg.cam_z;
  assign cam[2]   = cfg.cam_w;
  assign nrm[0]   = cfg.normal_x;
  assign nrm[1]   = cfg.normal_z;
  assign nrm[2]   = cfg.normal_w;

  for (genvar a = 0; a < hcsc_pkg::NumAxes; a++) begin : g_dot
    hcsc_axis_dot u_dot (
      .clk_i    (clk_i),
      .en_i     (en),
      .coord_i  (coord[a]),
      .cam_i    (cam[a]),
      .normal_i (nrm[a]),
      .half_i   (cfg.block_half),
      .dot_min_o(dmin[a]),
      .dot_max_o(dmax[a])
    );
  end

  hcsc_interior #(
    .CELLS_PER_SIDE(CELLS_PER_SIDE)
  ) u_interior (
    .clk_i     (clk_i),
    .en_i      (en.s1),
    .cell_i    (s_axis_tdata_i[4*CW-1:0]),
    .group_i   (s_axis_tdata_i[8*CW-1:4*CW]),
    .interior_o(int1)
  );

  assign sum_min = hcsc_pkg::SumW'(dmin[0]) + hcsc_pkg::SumW'(dmin[1])
                 + hcsc_pkg::SumW'(dmin[2]);
  assign sum_max = hcsc_pkg::SumW'(dmax[0]) + hcsc_pkg::SumW'(dmax[1])
                 + hcsc_pkg::SumW'(dmax[2]);

  assign crosses_d = (sum_min[hcsc_pkg::SumW-1] || (sum_min == '0))
                   && !sum_max[hcsc_pkg::SumW-1];
  assign visible_d = crosses_d && !int3_q;

  always_ff @(posedge clk_i) begin
    if (en.s2) int2_q <= int1;
    if (en.s3) int3_q <= int2_q;
    if (en4) begin
      crosses_q <= crosses_d;
      visible_q <= visible_d;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {{(hcsc_pkg::OutDataW - 2){1'b0}}, visible_q, crosses_q};

  a_visible_needs_cross : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (crosses_q || !visible_q))
    else $error("visible result without plane crossing");

  a_ready_when_sink_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output side is ready");

  a_out_from_stage3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v3_q))
    else $error("output valid without a transaction in the last stage");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for hyperplane_cell_slice_cull: drives cell transactions,
// predicts slice-plane crossing and visibility per cell, compares every result.
// Depends on hcsc_pkg and the hyperplane_cell_slice_cull RTL.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam longint CellsSide = longint'(hcsc_pkg::CellsPerSideDef);
  localparam logic [hcsc_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  // packed so that cx lands in the lowest bits of tdata
  typedef struct packed {
    logic [hcsc_pkg::CoordW-1:0] gw;
    logic [hcsc_pkg::CoordW-1:0] gz;
    logic [hcsc_pkg::CoordW-1:0] gy;
    logic [hcsc_pkg::CoordW-1:0] gx;
    logic [hcsc_pkg::CoordW-1:0] cw;
    logic [hcsc_pkg::CoordW-1:0] cz;
    logic [hcsc_pkg::CoordW-1:0] cy;
    logic [hcsc_pkg::CoordW-1:0] cx;
  } cell_item_t;

  typedef struct packed {
    logic visible;
    logic crosses;
  } cull_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [hcsc_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [hcsc_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [hcsc_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [hcsc_pkg::OutDataW-1:0] m_tdata;

  hyperplane_cell_slice_cull u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata)
  );

  hcsc_pkg::cfg_t cfg_m;
  cell_item_t     pending_q[$];
  cull_result_t   cull_q[$];
  cell_item_t     cur_item;
  logic           holding = 1'b0;
  int unsigned    send_idle = 0;
  int unsigned    recv_idle = 0;
  int unsigned    n_errors = 0;
  int unsigned    n_results = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  task automatic add_cell(cell_item_t it);
    pending_q = {pending_q, it};
  endtask

  function automatic cull_result_t predict_cull(cell_item_t it);
    longint half, sp, mn, mx, lo, hi, loc;
    longint crd[3], cam[3], nrm[3], cel[4], grp[4];
    logic interior;
    cull_result_t r;
    half = longint'(cfg_m.block_half);
    sp = half * 2;
    crd[0] = longint'($signed(it.cx));
    crd[1] = longint'($signed(it.cz));
    crd[2] = longint'($signed(it.cw));
    cam[0] = longint'($signed(cfg_m.cam_x));
    cam[1] = longint'($signed(cfg_m.cam_z));
    cam[2] = longint'($signed(cfg_m.cam_w));
    nrm[0] = longint'($signed(cfg_m.normal_x));
    nrm[1] = longint'($signed(cfg_m.normal_z));
    nrm[2] = longint'($signed(cfg_m.normal_w));
    mn = 0;
    mx = 0;
    for (int a = 0; a < 3; a++) begin
      lo = crd[a] * sp - cam[a] - half;
      hi = crd[a] * sp - cam[a] + half;
      if (nrm[a] > 0) begin
        mn += nrm[a] * lo;
        mx += nrm[a] * hi;
      end else begin
        mn += nrm[a] * hi;
        mx += nrm[a] * lo;
      end
    end
    cel[0] = longint'($signed(it.cx));
    cel[1] = longint'($signed(it.cy));
    cel[2] = longint'($signed(it.cz));
    cel[3] = longint'($signed(it.cw));
    grp[0] = longint'($signed(it.gx));
    grp[1] = longint'($signed(it.gy));
    grp[2] = longint'($signed(it.gz));
    grp[3] = longint'($signed(it.gw));
    interior = 1'b1;
    for (int a = 0; a < 4; a++) begin
      loc = cel[a] - grp[a] * CellsSide;
      if (!(loc > 0 && loc < CellsSide - 1)) interior = 1'b0;
    end
    r.crosses = (mn <= 0) && (mx >= 0);
    r.visible = r.crosses && !interior;
    return r;
  endfunction

  function automatic logic [hcsc_pkg::CoordW-1:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[hcsc_pkg::CoordW-1:0];
  endfunction

  function automatic cell_item_t mk_cell(longint cx, longint cy, longint cz, longint cw,
                                         longint gx, longint gy, longint gz, longint gw);
    cell_item_t it;
    it.cx = clamp16(cx);
    it.cy = clamp16(cy);
    it.cz = clamp16(cz);
    it.cw = clamp16(cw);
    it.gx = clamp16(gx);
    it.gy = clamp16(gy);
    it.gz = clamp16(gz);
    it.gw = clamp16(gw);
    return it;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        cull_q = {cull_q, predict_cull(cur_item)};
        holding = 1'b0;
      end
      if (!s_valid || s_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_item = pending_q.pop_front();
          holding = 1'b1;
          s_valid <= 1'b1;
          s_tdata <= cur_item;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    cull_result_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (cull_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = cull_q.pop_front();
          if (m_tdata[0] !== want.crosses)
            report($sformatf("result %0d crosses_plane exp %0b got %0b",
                             n_results, want.crosses, m_tdata[0]));
          if (m_tdata[1] !== want.visible)
            report($sformatf("result %0d visible exp %0b got %0b",
                             n_results, want.visible, m_tdata[1]));
        end
        n_results++;
      end
      m_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [hcsc_pkg::CfgIdxW-1:0] idx,
                           logic [hcsc_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      hcsc_pkg::CFG_CAM_X:      cfg_m.cam_x = data[hcsc_pkg::CamW-1:0];
      hcsc_pkg::CFG_CAM_Z:      cfg_m.cam_z = data[hcsc_pkg::CamW-1:0];
      hcsc_pkg::CFG_CAM_W:      cfg_m.cam_w = data[hcsc_pkg::CamW-1:0];
      hcsc_pkg::CFG_NORMAL_X:   cfg_m.normal_x = data[hcsc_pkg::NormW-1:0];
      hcsc_pkg::CFG_NORMAL_Z:   cfg_m.normal_z = data[hcsc_pkg::NormW-1:0];
      hcsc_pkg::CFG_NORMAL_W:   cfg_m.normal_w = data[hcsc_pkg::NormW-1:0];
      hcsc_pkg::CFG_BLOCK_HALF: cfg_m.block_half = data[hcsc_pkg::HalfW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // upper bits of narrow registers carry junk, which must be dropped
  task automatic load_cfg(hcsc_pkg::cfg_t c);
    logic [hcsc_pkg::CfgDataW-1:0] junk;
    junk = $urandom;
    write_reg(hcsc_pkg::CFG_CAM_X, c.cam_x);
    write_reg(hcsc_pkg::CFG_CAM_Z, c.cam_z);
    write_reg(hcsc_pkg::CFG_CAM_W, c.cam_w);
    write_reg(hcsc_pkg::CFG_NORMAL_X, {junk[15:0], c.normal_x});
    write_reg(hcsc_pkg::CFG_NORMAL_Z, {junk[31:16], c.normal_z});
    write_reg(hcsc_pkg::CFG_NORMAL_W, {junk[23:8], c.normal_w});
    write_reg(hcsc_pkg::CFG_BLOCK_HALF, {junk[7:0], c.block_half});
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || holding || cull_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [hcsc_pkg::NormW-1:0] rand_normal();
    int unsigned r;
    r = $urandom_range(11);
    if (r < 2) return '0;
    if (r == 2) return 16'h7FFF;
    if (r == 3) return 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic random_phase(int n_items);
    hcsc_pkg::cfg_t c;
    longint sp, q, rad, cam_a[3], ctr[4], cel[4], grp[4];
    int unsigned r;
    logic [31:0] raw;
    r = $urandom_range(9);
    if (r == 0) c.block_half = '0;
    else if (r == 1) c.block_half = 24'hFFFFFF;
    else if (r == 2) c.block_half = 24'($urandom);
    else c.block_half = 24'($urandom_range(1 << 18));
    c.normal_x = rand_normal();
    c.normal_z = rand_normal();
    c.normal_w = rand_normal();
    for (int a = 0; a < 3; a++) begin
      raw = $urandom;
      cam_a[a] = longint'($signed(raw)) >>> $urandom_range(20);
    end
    c.cam_x = cam_a[0][31:0];
    c.cam_z = cam_a[1][31:0];
    c.cam_w = cam_a[2][31:0];
    load_cfg(c);
    sp = longint'(c.block_half) * 2;
    // cells are clustered around the camera so that the plane cuts through them
    ctr[0] = (sp != 0) ? cam_a[0] / sp : longint'($urandom_range(40)) - 20;
    ctr[1] = longint'($urandom_range(400)) - 200;
    ctr[2] = (sp != 0) ? cam_a[1] / sp : longint'($urandom_range(40)) - 20;
    ctr[3] = (sp != 0) ? cam_a[2] / sp : longint'($urandom_range(40)) - 20;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 85) begin
        rad = longint'($urandom_range(10));
        for (int a = 0; a < 4; a++) begin
          cel[a] = ctr[a] + longint'($urandom_range(2 * rad)) - rad;
          if (cel[a] > 32767) cel[a] = 32767;
          if (cel[a] < -32768) cel[a] = -32768;
          q = cel[a] / CellsSide;
          if (cel[a] % CellsSide < 0) q--;
          r = $urandom_range(99);
          if (r < 70) grp[a] = q;
          else if (r < 85) grp[a] = q + (($urandom_range(1) != 0) ? 1 : -1);
          else grp[a] = longint'($signed(16'($urandom)));
        end
        add_cell(mk_cell(cel[0], cel[1], cel[2], cel[3],
                         grp[0], grp[1], grp[2], grp[3]));
      end else begin
        add_cell(cell_item_t'({$urandom, $urandom, $urandom, $urandom}));
      end
    end
    drain();
  endtask

  initial begin
    cfg_m = '0;
    cfg_m.normal_w = hcsc_pkg::NormalWReset;
    cfg_m.block_half = hcsc_pkg::BlockHalfReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 35;
    recv_idle = 76;

    // reset values: plane w = 0, unit cells
    add_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0));
    add_cell(mk_cell(1, 1, 1, 1, 0, 0, 0, 0));
    add_cell(mk_cell(-1, -1, -1, -1, 0, 0, 0, 0));
    add_cell(mk_cell(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    add_cell(mk_cell(-32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, -32768));
    add_cell(mk_cell(5, 5, 5, 0, 0, 0, 0, 0));
    add_cell(mk_cell(100, 3, -100, 0, 0, 0, 0, 0));
    add_cell(mk_cell(-32768, 0, 0, 0, 32767, 0, 0, 0));
    drain();

    // plane at w = 3.5: boxes of cells 3 and 4 touch it; interior cells culled
    write_reg(hcsc_pkg::CFG_CAM_W, 32'h0003_8000);
    add_cell(mk_cell(3, 3, 3, 3, 0, 0, 0, 0));
    add_cell(mk_cell(6, 6, 6, 4, 0, 0, 0, 0));
    add_cell(mk_cell(3, 3, 3, 3, 1, 0, 0, 0));
    add_cell(mk_cell(0, 3, 3, 3, 0, 0, 0, 0));
    add_cell(mk_cell(7, 3, 3, 4, 0, 0, 0, 0));
    add_cell(mk_cell(3, 3, 3, 5, 0, 0, 0, 0));
    drain();

    // all-zero normal
    write_reg(hcsc_pkg::CFG_NORMAL_W, 32'hABCD_0000);
    add_cell(mk_cell(1234, -5, 32767, -32768, 7, 7, 7, 7));
    add_cell(mk_cell(-999, 0, 42, 17, 0, 0, 0, 0));
    drain();

    // zero half size: point at -cam, on the plane or not
    write_reg(hcsc_pkg::CFG_BLOCK_HALF, 32'hFF00_0000);
    write_reg(hcsc_pkg::CFG_NORMAL_X, 32'h0000_4000);
    write_reg(hcsc_pkg::CFG_NORMAL_W, 32'h0000_C000);
    write_reg(hcsc_pkg::CFG_CAM_X, 32'h0001_0000);
    write_reg(hcsc_pkg::CFG_CAM_W, 32'h0001_0000);
    add_cell(mk_cell(9, 9, 9, 9, 1, 1, 1, 1));
    add_cell(mk_cell(-4, 2, 8, 100, 0, 0, 0, 0));
    drain();
    write_reg(hcsc_pkg::CFG_CAM_W, 32'hFFFF_0000);
    add_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0));
    add_cell(mk_cell(3, 3, 3, 3, 0, 0, 0, 0));
    drain();

    // register extremes, and a write to an index past the list
    write_reg(hcsc_pkg::CFG_CAM_X, 32'h7FFF_FFFF);
    write_reg(hcsc_pkg::CFG_CAM_Z, 32'h8000_0000);
    write_reg(hcsc_pkg::CFG_CAM_W, 32'h7FFF_FFFF);
    write_reg(hcsc_pkg::CFG_NORMAL_X, 32'h0000_7FFF);
    write_reg(hcsc_pkg::CFG_NORMAL_Z, 32'h0000_8000);
    write_reg(hcsc_pkg::CFG_NORMAL_W, 32'h0000_8000);
    write_reg(hcsc_pkg::CFG_BLOCK_HALF, 32'h00FF_FFFF);
    write_reg(CfgIdxSpare, $urandom);
    add_cell(mk_cell(32767, 32767, -32768, 32767, 0, 0, 0, 0));
    add_cell(mk_cell(-32768, -32768, 32767, -32768, 0, 0, 0, 0));
    drain();
    write_reg(hcsc_pkg::CFG_CAM_X, 32'h8000_0000);
    write_reg(hcsc_pkg::CFG_CAM_Z, 32'h7FFF_FFFF);
    write_reg(hcsc_pkg::CFG_NORMAL_X, 32'h0000_8000);
    write_reg(hcsc_pkg::CFG_NORMAL_Z, 32'h0000_7FFF);
    add_cell(mk_cell(-32768, 1, 32767, 0, -32768, 0, 32767, 0));
    add_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 76;
        recv_idle = 35;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_phase(155);
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
